FILE: src/linear_probe_hash_map_macros.svh
// assertion macros used by the hash map control module
`ifndef LINEAR_PROBE_HASH_MAP_MACROS_SVH
`define LINEAR_PROBE_HASH_MAP_MACROS_SVH

// property checked on every rising clock edge outside reset
`define LPHM_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("lphm assertion failed");

// condition that must hold in the cycle after a trigger
`define LPHM_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("lphm sequencing assertion failed");

`endif

FILE: src/lphm_pkg.sv
// shared constants, types and helpers of the linear probe hash map
package lphm_pkg;

  localparam int unsigned SLOT_DEPTH = 1024;
  localparam int unsigned SLOT_AW    = $clog2(SLOT_DEPTH);
  localparam int unsigned SIZE_W     = $clog2(SLOT_DEPTH + 1);
  localparam int unsigned CNT_W      = SIZE_W;
  localparam int unsigned KEY_W      = 32;
  localparam int unsigned VAL_W      = 32;
  localparam int unsigned HASH_W     = 32;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned MOD_BITS   = 4;
  localparam int unsigned MOD_STEPS  = HASH_W / MOD_BITS;
  localparam int unsigned MOD_CW     = $clog2(MOD_STEPS);
  localparam logic [SIZE_W-1:0] RESET_SIZE = SIZE_W'(1021);

  typedef enum logic [MODE_W-1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_DELETE = 2'd2,
    MODE_SPARE  = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND     = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_INSERTED  = 3'd2,
    ST_PRESENT   = 3'd3,
    ST_FULL      = 3'd4,
    ST_DELETED   = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    WA_PROBE  = 2'd0,
    WA_REFLOW = 2'd1,
    WA_CLEAR  = 2'd2
  } waddr_e;

  typedef struct packed {
    logic              valid;
    logic [HASH_W-1:0] hash;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
  } slot_t;

  typedef struct packed {
    logic    take_item;
    logic    mod_key;
    logic    mod_mov;
    logic    load_home;
    logic    load_start;
    logic    p_next;
    logic    r_from_p;
    logic    r_next;
    logic    rd_en;
    logic    rd_reflow;
    logic    wr_en;
    waddr_e  wr_addr;
    logic    wr_valid;
    logic    wr_mov;
    logic    latch_mov;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    res_set;
    status_e res_status;
    logic    res_val;
    logic    ld_rsp;
    logic    clr_next;
  } cmd_t;

  typedef struct packed {
    logic  clr_last;
    logic  mod_done;
    logic  rd_valid;
    logic  rd_match;
    logic  p_wrap;
    logic  r_stop;
    mode_e mode;
    logic  over_limit;
    logic  rsp_free;
  } stat_t;

  // next probe slot with wrap at the table size
  function automatic logic [SLOT_AW-1:0] next_slot(input logic [SLOT_AW-1:0] idx,
                                                   input logic [SIZE_W-1:0] size);
    logic [SIZE_W-1:0] inc;
    inc = SIZE_W'(idx) + SIZE_W'(1);
    return (inc >= size) ? '0 : inc[SLOT_AW-1:0];
  endfunction

endpackage

FILE: src/lphm_ifs.sv
// valid/ready channel interfaces of the hash map
interface lphm_req_if import lphm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [KEY_W-1:0]  key;
  logic [HASH_W-1:0] key_hash;
  logic [VAL_W-1:0]  new_value;
  modport source (output valid, mode, key, key_hash, new_value, input ready);
  modport sink (input valid, mode, key, key_hash, new_value, output ready);
endinterface

interface lphm_rsp_if import lphm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [VAL_W-1:0]    value_out;
  logic [CNT_W-1:0]    entry_total;
  modport source (output valid, status, value_out, entry_total, input ready);
  modport sink (input valid, status, value_out, entry_total, output ready);
endinterface

interface lphm_cfg_if import lphm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] table_size;
  modport source (output valid, table_size, input ready);
  modport sink (input valid, table_size, output ready);
endinterface

FILE: src/lphm_datapath.sv
// slot store, hash remainder unit, probe pointers and result registers
module lphm_datapath import lphm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [MODE_W-1:0]  mode_i,
  input  logic [KEY_W-1:0]   key_i,
  input  logic [HASH_W-1:0]  hash_i,
  input  logic [VAL_W-1:0]   nval_i,
  lphm_rsp_if.source         out_ch,
  lphm_cfg_if.sink           cfg_ch,
  input  cmd_t               cmd_i,
  output stat_t              st_o
);

  slot_t mem [SLOT_DEPTH];
  slot_t rdata_q;
  slot_t wdata;
  slot_t mov_q;

  logic [SIZE_W-1:0]   size_q;
  logic [SIZE_W-1:0]   size_w;
  mode_e               mode_q;
  logic [KEY_W-1:0]    key_q;
  logic [HASH_W-1:0]   hash_q;
  logic [VAL_W-1:0]    nval_q;

  logic [HASH_W-1:0]   src_q;
  logic [SIZE_W-1:0]   rem_q, rem_d;
  logic [MOD_CW-1:0]   mcnt_q;
  logic                mbusy_q, mdone_q;

  logic [SLOT_AW-1:0]  p_q, start_q, home_q, r_q, clr_q;
  logic [SLOT_AW-1:0]  waddr, raddr;
  logic [CNT_W-1:0]    cnt_q;

  status_e             res_status_q;
  logic [VAL_W-1:0]    res_value_q;
  logic                out_valid_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [VAL_W-1:0]    out_value_q;
  logic [CNT_W-1:0]    out_total_q;

  // table size clamped to the range from 1 to the store depth
  always_comb begin
    if (size_q == '0) begin
      size_w = SIZE_W'(1);
    end else if (size_q > SIZE_W'(SLOT_DEPTH)) begin
      size_w = SIZE_W'(SLOT_DEPTH);
    end else begin
      size_w = size_q;
    end
  end

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= RESET_SIZE;
    end else if (cfg_ch.valid) begin
      size_q <= cfg_ch.table_size;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_item) begin
      mode_q <= mode_e'(mode_i);
      key_q  <= key_i;
      hash_q <= hash_i;
      nval_q <= nval_i;
    end
  end

  // remainder by restoring steps, MOD_BITS hash bits per cycle
  always_comb begin
    logic [SIZE_W:0] t;
    rem_d = rem_q;
    for (int k = 0; k < MOD_BITS; k++) begin
      t = {rem_d, src_q[HASH_W-1-k]};
      if (t >= {1'b0, size_w}) begin
        t = t - {1'b0, size_w};
      end
      rem_d = t[SIZE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mbusy_q <= 1'b0;
      mdone_q <= 1'b0;
      mcnt_q  <= '0;
    end else if (cmd_i.mod_key || cmd_i.mod_mov) begin
      mbusy_q <= 1'b1;
      mdone_q <= 1'b0;
      mcnt_q  <= '0;
    end else if (mbusy_q) begin
      mcnt_q <= mcnt_q + MOD_CW'(1);
      if (mcnt_q == MOD_CW'(MOD_STEPS - 1)) begin
        mbusy_q <= 1'b0;
        mdone_q <= 1'b1;
      end
    end else begin
      mdone_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mod_key) begin
      src_q <= hash_i;
      rem_q <= '0;
    end else if (cmd_i.mod_mov) begin
      src_q <= rdata_q.hash;
      rem_q <= '0;
    end else if (mbusy_q) begin
      src_q <= src_q << MOD_BITS;
      rem_q <= rem_d;
    end
  end

  // probe pointers and the register of the entry being moved
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_home) begin
      p_q     <= rem_q[SLOT_AW-1:0];
      start_q <= rem_q[SLOT_AW-1:0];
      home_q  <= rem_q[SLOT_AW-1:0];
    end else if (cmd_i.load_start) begin
      p_q     <= rem_q[SLOT_AW-1:0];
      start_q <= rem_q[SLOT_AW-1:0];
    end else if (cmd_i.p_next) begin
      p_q <= next_slot(p_q, size_w);
    end
    if (cmd_i.r_from_p) begin
      r_q <= next_slot(p_q, size_w);
    end else if (cmd_i.r_next) begin
      r_q <= next_slot(r_q, size_w);
    end
    if (cmd_i.latch_mov) begin
      mov_q <= rdata_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_next) begin
      clr_q <= clr_q + SLOT_AW'(1);
    end
  end

  // slot store
  always_comb begin
    case (cmd_i.wr_addr)
      WA_REFLOW: waddr = r_q;
      WA_CLEAR:  waddr = clr_q;
      default:   waddr = p_q;
    endcase
    raddr = cmd_i.rd_reflow ? r_q : p_q;
    if (cmd_i.wr_mov) begin
      wdata = mov_q;
    end else begin
      wdata = '{valid: 1'b0, hash: hash_q, key: key_q, value: nval_q};
    end
    wdata.valid = cmd_i.wr_valid;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[waddr] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_inc && cnt_q < CNT_W'(SLOT_DEPTH)) begin
      cnt_q <= cnt_q + CNT_W'(1);
    end else if (cmd_i.cnt_dec && cnt_q != '0) begin
      cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_set) begin
      res_status_q <= cmd_i.res_status;
      res_value_q  <= cmd_i.res_val ? rdata_q.value : '0;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.ld_rsp) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_rsp) begin
      out_status_q <= res_status_q;
      out_value_q  <= res_value_q;
      out_total_q  <= cnt_q;
    end
  end

  assign out_ch.valid       = out_valid_q;
  assign out_ch.status      = out_status_q;
  assign out_ch.value_out   = out_value_q;
  assign out_ch.entry_total = out_total_q;

  assign st_o.clr_last   = (clr_q == SLOT_AW'(SLOT_DEPTH - 1));
  assign st_o.mod_done   = mdone_q;
  assign st_o.rd_valid   = rdata_q.valid;
  assign st_o.rd_match   = (rdata_q.hash == hash_q) && (rdata_q.key == key_q);
  assign st_o.p_wrap     = (next_slot(p_q, size_w) == start_q);
  assign st_o.r_stop     = (next_slot(r_q, size_w) == home_q);
  assign st_o.mode       = mode_q;
  assign st_o.over_limit = (({2'b0, cnt_q} * (CNT_W + 2)'(3)) >=
                            ({2'b0, size_w} * (CNT_W + 2)'(2)));
  assign st_o.rsp_free   = !out_valid_q || out_ch.ready;

endmodule

FILE: src/lphm_ctrl.sv
// control state machine of the hash map
`include "linear_probe_hash_map_macros.svh"
module lphm_ctrl import lphm_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t st_i,
  output cmd_t  cmd_o
);

  typedef enum logic [10:0] {
    S_CLEAR = 11'b000_0000_0001,
    S_IDLE  = 11'b000_0000_0010,
    S_MOD   = 11'b000_0000_0100,
    S_PRD   = 11'b000_0000_1000,
    S_PCHK  = 11'b000_0001_0000,
    S_RRD   = 11'b000_0010_0000,
    S_RCHK  = 11'b000_0100_0000,
    S_MMOD  = 11'b000_1000_0000,
    S_MRD   = 11'b001_0000_0000,
    S_MCHK  = 11'b010_0000_0000,
    S_RESP  = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   hit;

  assign hit = st_i.rd_valid && st_i.rd_match;

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    state_d    = state_q;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.wr_en    = 1'b1;
        cmd_o.wr_addr  = WA_CLEAR;
        cmd_o.clr_next = 1'b1;
        if (st_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take_item = 1'b1;
          cmd_o.mod_key   = 1'b1;
          state_d         = S_MOD;
        end
      end
      S_MOD: begin
        if (st_i.mod_done) begin
          cmd_o.load_home = 1'b1;
          state_d         = S_PRD;
        end
      end
      S_PRD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_PCHK;
      end
      S_PCHK: begin
        if (!hit && st_i.rd_valid && !st_i.p_wrap) begin
          cmd_o.p_next = 1'b1;
          state_d      = S_PRD;
        end else begin
          cmd_o.res_set = 1'b1;
          state_d       = S_RESP;
          case (st_i.mode)
            MODE_INSERT: begin
              if (hit) begin
                cmd_o.res_status = ST_PRESENT;
                cmd_o.res_val    = 1'b1;
              end else if (st_i.over_limit || st_i.rd_valid) begin
                cmd_o.res_status = ST_FULL;
              end else begin
                cmd_o.wr_en      = 1'b1;
                cmd_o.wr_addr    = WA_PROBE;
                cmd_o.wr_valid   = 1'b1;
                cmd_o.cnt_inc    = 1'b1;
                cmd_o.res_status = ST_INSERTED;
              end
            end
            MODE_DELETE: begin
              if (hit) begin
                cmd_o.res_status = ST_DELETED;
                cmd_o.res_val    = 1'b1;
                cmd_o.wr_en      = 1'b1;
                cmd_o.wr_addr    = WA_PROBE;
                cmd_o.cnt_dec    = 1'b1;
                cmd_o.r_from_p   = 1'b1;
                state_d          = S_RRD;
              end else begin
                cmd_o.res_status = ST_NOT_FOUND;
              end
            end
            default: begin
              cmd_o.res_status = hit ? ST_FOUND : ST_NOT_FOUND;
              cmd_o.res_val    = hit;
            end
          endcase
        end
      end
      S_RRD: begin
        cmd_o.rd_en     = 1'b1;
        cmd_o.rd_reflow = 1'b1;
        state_d         = S_RCHK;
      end
      S_RCHK: begin
        if (!st_i.rd_valid) begin
          state_d = S_RESP;
        end else begin
          cmd_o.latch_mov = 1'b1;
          cmd_o.mod_mov   = 1'b1;
          cmd_o.wr_en     = 1'b1;
          cmd_o.wr_addr   = WA_REFLOW;
          state_d         = S_MMOD;
        end
      end
      S_MMOD: begin
        if (st_i.mod_done) begin
          cmd_o.load_start = 1'b1;
          state_d          = S_MRD;
        end
      end
      S_MRD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_MCHK;
      end
      S_MCHK: begin
        if (st_i.rd_valid && !st_i.p_wrap) begin
          cmd_o.p_next = 1'b1;
          state_d      = S_MRD;
        end else begin
          if (!st_i.rd_valid) begin
            cmd_o.wr_en    = 1'b1;
            cmd_o.wr_addr  = WA_PROBE;
            cmd_o.wr_valid = 1'b1;
            cmd_o.wr_mov   = 1'b1;
          end
          cmd_o.r_next = 1'b1;
          state_d      = st_i.r_stop ? S_RESP : S_RRD;
        end
      end
      S_RESP: begin
        if (st_i.rsp_free) begin
          cmd_o.ld_rsp = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  `LPHM_ASSERT_NEXT(a_accept_starts_mod, in_valid_i && in_ready_o, state_q == S_MOD)
  `LPHM_ASSERT(a_mod_done_waited, st_i.mod_done |-> (state_q == S_MOD || state_q == S_MMOD))
  `LPHM_ASSERT(a_rsp_into_free_reg, cmd_o.ld_rsp |-> st_i.rsp_free)
  `LPHM_ASSERT(a_clear_addr_only_sweep, (cmd_o.wr_en && state_q != S_CLEAR) |-> cmd_o.wr_addr != WA_CLEAR)

endmodule

FILE: src/linear_probe_hash_map.sv
// top level of the linear probe hash map
// Key/value map over a 1024-slot store with linear probing from slot
// key_hash mod table_size. After reset the block sweeps the store once to
// clear the slot valid bits, one slot per cycle, and takes no item during
// that sweep (table_size writes are taken). Each item then has an accept
// step, the hash remainder (4 hash bits a cycle), a store read and check per
// probed slot and a load of the result register. A delete also walks the
// following entries up to the first empty slot or back round to the home
// slot; each moved entry is cleared, gets its remainder again and is placed
// by probing from its own home slot. The slot store has one read and one
// write port, and the remainder unit is shared by the key and the moved
// entries. The result register lets a finished result wait for its transfer
// while the next item is already taken.
module linear_probe_hash_map import lphm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  lphm_req_if.sink   in_ch,
  lphm_rsp_if.source out_ch,
  lphm_cfg_if.sink   cfg_ch
);

  // command and status between the state machine and the datapath
  cmd_t  cmd;
  stat_t st;

  // controller sequences the clear sweep, probe, insert, delete and reflow
  lphm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  // datapath holds the store, pointers, counters and result register
  lphm_datapath u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .mode_i (in_ch.mode),
    .key_i  (in_ch.key),
    .hash_i (in_ch.key_hash),
    .nval_i (in_ch.new_value),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch),
    .cmd_i  (cmd),
    .st_o   (st)
  );

endmodule
